[hdl/clc_pkg.sv]
package clc_pkg;

  localparam int MAX_COLUMNS = 20;
  localparam int COL_W       = 5;
  localparam int ROW_W       = 2;

  localparam logic [COL_W-1:0] MAX_LAST_COL = COL_W'(MAX_COLUMNS - 1);

  // command codes
  localparam logic [3:0] CMD_PUTC   = 4'd0;
  localparam logic [3:0] CMD_MOVE   = 4'd1;
  localparam logic [3:0] CMD_LEFT   = 4'd2;
  localparam logic [3:0] CMD_RIGHT  = 4'd3;
  localparam logic [3:0] CMD_UP     = 4'd4;
  localparam logic [3:0] CMD_DOWN   = 4'd5;
  localparam logic [3:0] CMD_RETURN = 4'd6;
  localparam logic [3:0] CMD_CLEAR  = 4'd7;
  localparam logic [3:0] CMD_HOME   = 4'd8;
  localparam logic [3:0] CMD_CURSOR = 4'd9;
  localparam logic [3:0] CMD_SAVE   = 4'd10;
  localparam logic [3:0] CMD_RECALL = 4'd11;
  localparam logic [3:0] CMD_ERASE  = 4'd12;

  // configuration register indexes
  localparam logic [1:0] CFG_DISPLAY_MODE = 2'd0;
  localparam logic [1:0] CFG_LAST_ROW     = 2'd1;
  localparam logic [1:0] CFG_LAST_COL     = 2'd2;

  // display instruction bytes and characters
  localparam logic [7:0] INSTR_CLEAR    = 8'h01;
  localparam logic [7:0] INSTR_HOME     = 8'h03;
  localparam logic [7:0] INSTR_DISP_ON  = 8'h0C;
  localparam logic [7:0] INSTR_SET_ADDR = 8'h80;
  localparam logic [7:0] CHAR_NEWLINE   = 8'h0A;
  localparam logic [7:0] CHAR_SPACE     = 8'h20;

  localparam logic [COL_W-1:0] SPLIT_COL = COL_W'(8);

  typedef enum logic [3:0] {
    S_IDLE,
    S_DISP,
    S_CLR,
    S_CHAR,
    S_RET,
    S_DOWN,
    S_MOVE,
    S_CHK,
    S_PDONE,
    S_HI,
    S_LO,
    S_FLUSH
  } state_t;

  typedef struct packed {
    logic [ROW_W-1:0] row;
    logic [COL_W-1:0] col;
  } pos_t;

  typedef struct packed {
    pos_t       pos;
    logic [7:0] instr;
  } move_res_t;

  function automatic logic [6:0] row_offset(input logic [ROW_W-1:0] row);
    logic [6:0] offs;
    case (row)
      2'd0:    offs = 7'h00;
      2'd1:    offs = 7'h40;
      2'd2:    offs = 7'h14;
      default: offs = 7'h54;
    endcase
    return offs;
  endfunction

endpackage

[hdl/clc_ifs.sv]
interface clc_in_if;
  logic       valid;
  logic       ready;
  logic [3:0] cmd;
  logic [7:0] char_code;
  logic [1:0] target_row;
  logic [4:0] target_col;
  logic       cursor_visible;
  logic       cursor_blink;

  modport source (output valid, cmd, char_code, target_row, target_col,
                  cursor_visible, cursor_blink, input ready);
  modport sink (input valid, cmd, char_code, target_row, target_col,
                cursor_visible, cursor_blink, output ready);
endinterface

interface clc_out_if;
  logic       valid;
  logic       ready;
  logic [3:0] nibble;
  logic       reg_select;
  logic       long_wait;
  logic       last;

  modport source (output valid, nibble, reg_select, long_wait, last, input ready);
  modport sink (input valid, nibble, reg_select, long_wait, last, output ready);
endinterface

interface clc_cfg_if;
  logic       valid;
  logic       ready;
  logic [1:0] idx;
  logic [4:0] data;

  modport source (output valid, idx, data, input ready);
  modport sink (input valid, idx, data, output ready);
endinterface

[hdl/char_lcd_cursor_controller_core.sv]
// Text-terminal front end for a character display on a 4-bit bus. Each command beat on
// in_bus turns into a run of nibble beats on out_bus, high nibble of every byte first,
// with last set on the final nibble of the command; commands that write nothing (save,
// unused codes, erase at the end of a line) give no beat at all. in_bus.ready is high
// only while the sequencer is idle. A command's nibbles go out one per cycle while out_bus
// takes them, with bookkeeping steps between bytes (a few per character, one per address
// write otherwise); every address write goes through one shared clamp-and-address unit.
// The last nibble of a command is held back until the bookkeeping steps that follow the
// final byte are done. Configuration writes are accepted in every cycle and must only be
// made while no command is in flight.
module char_lcd_cursor_controller_core (
  input  logic          clk,
  input  logic          rst_n,
  clc_in_if.sink        in_bus,
  clc_out_if.source     out_bus,
  clc_cfg_if.sink       cfg_bus
);

  localparam int CW = clc_pkg::COL_W;
  localparam int RW = clc_pkg::ROW_W;

  // configuration
  logic          display_mode_r, display_mode_nxt;
  logic [RW-1:0] last_row_r, last_row_nxt;
  logic [CW-1:0] last_col_r, last_col_nxt;
  logic [CW-1:0] lc;

  // sequencer
  clc_pkg::state_t state_r, state_nxt;
  clc_pkg::state_t ret_r, ret_nxt;

  // latched command
  logic [3:0]    cmd_r, cmd_nxt;
  logic [7:0]    char_r, char_nxt;
  logic [RW-1:0] trow_r, trow_nxt;
  logic [CW-1:0] tcol_r, tcol_nxt;
  logic          vis_r, vis_nxt;
  logic          blink_r, blink_nxt;

  // terminal state
  logic [CW-1:0] cur_col_r, cur_col_nxt;
  logic [RW-1:0] cur_row_r, cur_row_nxt;
  logic [CW-1:0] sav_col_r, sav_col_nxt;
  logic [RW-1:0] sav_row_r, sav_row_nxt;
  logic          clr_pend_r, clr_pend_nxt;

  // move target and erase count
  clc_pkg::pos_t tgt_r, tgt_nxt;
  logic          keep_r, keep_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;

  // byte being written
  logic [7:0] byte_r, byte_nxt;
  logic       rs_r, rs_nxt;
  logic       lw_r, lw_nxt;

  // one nibble held back until we know whether it is the last
  logic       pend_valid_r, pend_valid_nxt;
  logic [3:0] pend_nib_r, pend_nib_nxt;
  logic       pend_rs_r, pend_rs_nxt;
  logic       pend_lw_r, pend_lw_nxt;

  // output register
  logic       out_valid_r, out_valid_nxt;
  logic [3:0] out_nib_r, out_nib_nxt;
  logic       out_rs_r, out_rs_nxt;
  logic       out_lw_r, out_lw_nxt;
  logic       out_last_r, out_last_nxt;

  logic out_free;
  logic push_ok;
  logic [3:0] push_nib;
  logic [RW:0] row_inc;
  logic        down_wrap;
  logic [RW-1:0] down_row;
  logic [CW:0]   col_inc;
  logic [7:0]    put_char;

  clc_pkg::pos_t     mv_req;
  clc_pkg::move_res_t mv_res;

  assign lc = (last_col_r > clc_pkg::MAX_LAST_COL) ? clc_pkg::MAX_LAST_COL : last_col_r;

  assign out_free = !out_valid_r || out_bus.ready;
  assign push_ok  = !pend_valid_r || out_free;

  assign row_inc   = {1'b0, cur_row_r} + (RW+1)'(1);
  assign down_wrap = row_inc > {1'b0, last_row_r};
  assign down_row  = down_wrap ? '0 : row_inc[RW-1:0];
  assign col_inc   = {1'b0, cur_col_r} + (CW+1)'(1);
  // erase writes spaces the way put char does
  assign put_char  = (cmd_r == clc_pkg::CMD_ERASE) ? clc_pkg::CHAR_SPACE : char_r;

  assign in_bus.ready  = (state_r == clc_pkg::S_IDLE);
  assign cfg_bus.ready = 1'b1;

  assign out_bus.valid      = out_valid_r;
  assign out_bus.nibble     = out_nib_r;
  assign out_bus.reg_select = out_rs_r;
  assign out_bus.long_wait  = out_lw_r;
  assign out_bus.last       = out_last_r;

  // shared clamp and address unit: return, down and every other move use it in turn
  always_comb begin
    case (state_r)
      clc_pkg::S_RET: begin
        mv_req.row = cur_row_r;
        mv_req.col = '0;
      end
      clc_pkg::S_DOWN: begin
        mv_req.row = down_row;
        mv_req.col = cur_col_r;
      end
      default: begin
        mv_req = tgt_r;
      end
    endcase
  end

  clc_move_unit u_move (
    .req          (mv_req),
    .display_mode (display_mode_r),
    .last_row     (last_row_r),
    .last_col_eff (lc),
    .res          (mv_res)
  );

  always_comb begin
    push_nib = (state_r == clc_pkg::S_HI) ? byte_r[7:4] : byte_r[3:0];
  end

  always_comb begin
    state_nxt        = state_r;
    ret_nxt          = ret_r;
    cmd_nxt          = cmd_r;
    char_nxt         = char_r;
    trow_nxt         = trow_r;
    tcol_nxt         = tcol_r;
    vis_nxt          = vis_r;
    blink_nxt        = blink_r;
    cur_col_nxt      = cur_col_r;
    cur_row_nxt      = cur_row_r;
    sav_col_nxt      = sav_col_r;
    sav_row_nxt      = sav_row_r;
    clr_pend_nxt     = clr_pend_r;
    tgt_nxt          = tgt_r;
    keep_nxt         = keep_r;
    cnt_nxt          = cnt_r;
    byte_nxt         = byte_r;
    rs_nxt           = rs_r;
    lw_nxt           = lw_r;
    pend_valid_nxt   = pend_valid_r;
    pend_nib_nxt     = pend_nib_r;
    pend_rs_nxt      = pend_rs_r;
    pend_lw_nxt      = pend_lw_r;
    out_valid_nxt    = out_valid_r && !out_bus.ready;
    out_nib_nxt      = out_nib_r;
    out_rs_nxt       = out_rs_r;
    out_lw_nxt       = out_lw_r;
    out_last_nxt     = out_last_r;
    display_mode_nxt = display_mode_r;
    last_row_nxt     = last_row_r;
    last_col_nxt     = last_col_r;

    // configuration writes
    if (cfg_bus.valid) begin
      unique case (cfg_bus.idx)
        clc_pkg::CFG_DISPLAY_MODE: display_mode_nxt = cfg_bus.data[0];
        clc_pkg::CFG_LAST_ROW:     last_row_nxt     = cfg_bus.data[RW-1:0];
        clc_pkg::CFG_LAST_COL:     last_col_nxt     = cfg_bus.data;
        default: ;
      endcase
    end

    unique case (state_r)
      clc_pkg::S_IDLE: begin
        if (in_bus.valid) begin
          cmd_nxt   = in_bus.cmd;
          char_nxt  = in_bus.char_code;
          trow_nxt  = in_bus.target_row;
          tcol_nxt  = in_bus.target_col;
          vis_nxt   = in_bus.cursor_visible;
          blink_nxt = in_bus.cursor_blink;
          state_nxt = clc_pkg::S_DISP;
        end
      end

      clc_pkg::S_DISP: begin
        keep_nxt  = 1'b0;
        state_nxt = clc_pkg::S_FLUSH;
        case (cmd_r)
          clc_pkg::CMD_PUTC: state_nxt = clc_pkg::S_CLR;
          clc_pkg::CMD_MOVE: begin
            tgt_nxt.row = trow_r;
            tgt_nxt.col = tcol_r;
            state_nxt   = clc_pkg::S_MOVE;
          end
          clc_pkg::CMD_LEFT: begin
            tgt_nxt.row = cur_row_r;
            tgt_nxt.col = (cur_col_r != '0) ? cur_col_r - CW'(1) : cur_col_r;
            state_nxt   = clc_pkg::S_MOVE;
          end
          clc_pkg::CMD_RIGHT: begin
            if (cur_col_r < lc) begin
              tgt_nxt.row = cur_row_r;
              tgt_nxt.col = col_inc[CW-1:0];
              state_nxt   = clc_pkg::S_MOVE;
            end else begin
              // at the last column: return, down, then rewrite the address
              state_nxt = clc_pkg::S_RET;
            end
          end
          clc_pkg::CMD_UP: begin
            tgt_nxt.row = (cur_row_r != '0) ? cur_row_r - RW'(1) : cur_row_r;
            tgt_nxt.col = cur_col_r;
            state_nxt   = clc_pkg::S_MOVE;
          end
          clc_pkg::CMD_DOWN:   state_nxt = clc_pkg::S_DOWN;
          clc_pkg::CMD_RETURN: state_nxt = clc_pkg::S_RET;
          clc_pkg::CMD_CLEAR: begin
            byte_nxt     = clc_pkg::INSTR_CLEAR;
            rs_nxt       = 1'b0;
            lw_nxt       = 1'b1;
            cur_col_nxt  = '0;
            cur_row_nxt  = '0;
            clr_pend_nxt = 1'b0;
            ret_nxt      = clc_pkg::S_FLUSH;
            state_nxt    = clc_pkg::S_HI;
          end
          clc_pkg::CMD_HOME: begin
            // home leaves a pending clear alone
            byte_nxt    = clc_pkg::INSTR_HOME;
            rs_nxt      = 1'b0;
            lw_nxt      = 1'b1;
            cur_col_nxt = '0;
            cur_row_nxt = '0;
            ret_nxt     = clc_pkg::S_FLUSH;
            state_nxt   = clc_pkg::S_HI;
          end
          clc_pkg::CMD_CURSOR: begin
            byte_nxt  = clc_pkg::INSTR_DISP_ON | {6'd0, vis_r, blink_r};
            rs_nxt    = 1'b0;
            lw_nxt    = 1'b0;
            ret_nxt   = clc_pkg::S_FLUSH;
            state_nxt = clc_pkg::S_HI;
          end
          clc_pkg::CMD_SAVE: begin
            sav_col_nxt = cur_col_r;
            sav_row_nxt = cur_row_r;
          end
          clc_pkg::CMD_RECALL: begin
            tgt_nxt.row = sav_row_r;
            tgt_nxt.col = sav_col_r;
            state_nxt   = clc_pkg::S_MOVE;
          end
          clc_pkg::CMD_ERASE: begin
            // one space per column up to, not including, the last column
            if (cur_col_r < lc) begin
              cnt_nxt   = lc - cur_col_r;
              state_nxt = clc_pkg::S_CLR;
            end
          end
          default: ;
        endcase
      end

      clc_pkg::S_CLR: begin
        // a pending clear blanks the screen before the next character
        if (clr_pend_r) begin
          byte_nxt     = clc_pkg::INSTR_CLEAR;
          rs_nxt       = 1'b0;
          lw_nxt       = 1'b1;
          cur_col_nxt  = '0;
          cur_row_nxt  = '0;
          clr_pend_nxt = 1'b0;
          ret_nxt      = clc_pkg::S_CHAR;
          state_nxt    = clc_pkg::S_HI;
        end else begin
          state_nxt = clc_pkg::S_CHAR;
        end
      end

      clc_pkg::S_CHAR: begin
        if (put_char == clc_pkg::CHAR_NEWLINE) begin
          state_nxt = clc_pkg::S_RET;
        end else begin
          byte_nxt    = put_char;
          rs_nxt      = 1'b1;
          lw_nxt      = 1'b0;
          cur_col_nxt = col_inc[CW-1:0];
          // past the last column: return and down follow
          ret_nxt     = (col_inc > {1'b0, lc}) ? clc_pkg::S_RET : clc_pkg::S_CHK;
          state_nxt   = clc_pkg::S_HI;
        end
      end

      clc_pkg::S_RET: begin
        byte_nxt     = mv_res.instr;
        rs_nxt       = 1'b0;
        lw_nxt       = 1'b0;
        cur_row_nxt  = mv_res.pos.row;
        cur_col_nxt  = mv_res.pos.col;
        clr_pend_nxt = 1'b0;
        ret_nxt      = (cmd_r == clc_pkg::CMD_RETURN) ? clc_pkg::S_FLUSH : clc_pkg::S_DOWN;
        state_nxt    = clc_pkg::S_HI;
      end

      clc_pkg::S_DOWN: begin
        byte_nxt     = mv_res.instr;
        rs_nxt       = 1'b0;
        lw_nxt       = 1'b0;
        cur_row_nxt  = mv_res.pos.row;
        cur_col_nxt  = mv_res.pos.col;
        // wrapping past the last row arms the clear
        clr_pend_nxt = down_wrap;
        state_nxt    = clc_pkg::S_HI;
        if (cmd_r == clc_pkg::CMD_RIGHT) begin
          tgt_nxt  = mv_res.pos;
          keep_nxt = 1'b1;
          ret_nxt  = clc_pkg::S_MOVE;
        end else if (cmd_r == clc_pkg::CMD_DOWN) begin
          ret_nxt = clc_pkg::S_FLUSH;
        end else begin
          ret_nxt = clc_pkg::S_CHK;
        end
      end

      clc_pkg::S_MOVE: begin
        byte_nxt    = mv_res.instr;
        rs_nxt      = 1'b0;
        lw_nxt      = 1'b0;
        cur_row_nxt = mv_res.pos.row;
        cur_col_nxt = mv_res.pos.col;
        if (!keep_r) begin
          clr_pend_nxt = 1'b0;
        end
        ret_nxt   = ((cmd_r == clc_pkg::CMD_PUTC) || (cmd_r == clc_pkg::CMD_ERASE)) ?
                    clc_pkg::S_PDONE : clc_pkg::S_FLUSH;
        state_nxt = clc_pkg::S_HI;
      end

      clc_pkg::S_CHK: begin
        // split addressing: column 8 needs an explicit jump to the second half
        if (!display_mode_r && (cur_col_r == clc_pkg::SPLIT_COL)) begin
          tgt_nxt.row = '0;
          tgt_nxt.col = clc_pkg::SPLIT_COL;
          keep_nxt    = 1'b0;
          state_nxt   = clc_pkg::S_MOVE;
        end else begin
          state_nxt = clc_pkg::S_PDONE;
        end
      end

      clc_pkg::S_PDONE: begin
        if ((cmd_r == clc_pkg::CMD_ERASE) && (cnt_r > CW'(1))) begin
          cnt_nxt   = cnt_r - CW'(1);
          state_nxt = clc_pkg::S_CLR;
        end else begin
          state_nxt = clc_pkg::S_FLUSH;
        end
      end

      clc_pkg::S_HI, clc_pkg::S_LO: begin
        if (push_ok) begin
          if (pend_valid_r) begin
            out_valid_nxt = 1'b1;
            out_nib_nxt   = pend_nib_r;
            out_rs_nxt    = pend_rs_r;
            out_lw_nxt    = pend_lw_r;
            out_last_nxt  = 1'b0;
          end
          pend_valid_nxt = 1'b1;
          pend_nib_nxt   = push_nib;
          pend_rs_nxt    = rs_r;
          pend_lw_nxt    = lw_r;
          state_nxt      = (state_r == clc_pkg::S_HI) ? clc_pkg::S_LO : ret_r;
        end
      end

      clc_pkg::S_FLUSH: begin
        // the held nibble goes out as the last beat of the command
        if (!pend_valid_r) begin
          state_nxt = clc_pkg::S_IDLE;
        end else if (out_free) begin
          out_valid_nxt  = 1'b1;
          out_nib_nxt    = pend_nib_r;
          out_rs_nxt     = pend_rs_r;
          out_lw_nxt     = pend_lw_r;
          out_last_nxt   = 1'b1;
          pend_valid_nxt = 1'b0;
          state_nxt      = clc_pkg::S_IDLE;
        end
      end

      default: state_nxt = clc_pkg::S_IDLE;
    endcase
  end

  // control and terminal state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r        <= clc_pkg::S_IDLE;
      display_mode_r <= 1'b1;
      last_row_r     <= RW'(1);
      last_col_r     <= CW'(15);
      cur_col_r      <= '0;
      cur_row_r      <= '0;
      sav_col_r      <= '0;
      sav_row_r      <= '0;
      clr_pend_r     <= 1'b0;
      pend_valid_r   <= 1'b0;
      out_valid_r    <= 1'b0;
    end else begin
      state_r        <= state_nxt;
      display_mode_r <= display_mode_nxt;
      last_row_r     <= last_row_nxt;
      last_col_r     <= last_col_nxt;
      cur_col_r      <= cur_col_nxt;
      cur_row_r      <= cur_row_nxt;
      sav_col_r      <= sav_col_nxt;
      sav_row_r      <= sav_row_nxt;
      clr_pend_r     <= clr_pend_nxt;
      pend_valid_r   <= pend_valid_nxt;
      out_valid_r    <= out_valid_nxt;
    end
  end

  // payload and working registers
  always_ff @(posedge clk) begin
    ret_r      <= ret_nxt;
    cmd_r      <= cmd_nxt;
    char_r     <= char_nxt;
    trow_r     <= trow_nxt;
    tcol_r     <= tcol_nxt;
    vis_r      <= vis_nxt;
    blink_r    <= blink_nxt;
    tgt_r      <= tgt_nxt;
    keep_r     <= keep_nxt;
    cnt_r      <= cnt_nxt;
    byte_r     <= byte_nxt;
    rs_r       <= rs_nxt;
    lw_r       <= lw_nxt;
    pend_nib_r <= pend_nib_nxt;
    pend_rs_r  <= pend_rs_nxt;
    pend_lw_r  <= pend_lw_nxt;
    out_nib_r  <= out_nib_nxt;
    out_rs_r   <= out_rs_nxt;
    out_lw_r   <= out_lw_nxt;
    out_last_r <= out_last_nxt;
  end

endmodule

[hdl/clc_move_unit.sv]
// clamps a requested position and forms the set-address instruction
module clc_move_unit (
  input  clc_pkg::pos_t                   req,
  input  logic                            display_mode,
  input  logic [clc_pkg::ROW_W-1:0]       last_row,
  input  logic [clc_pkg::COL_W-1:0]       last_col_eff,
  output clc_pkg::move_res_t              res
);

  logic [clc_pkg::ROW_W-1:0] row_c;
  logic [clc_pkg::COL_W-1:0] col_c;
  logic [6:0]                addr;

  always_comb begin
    row_c = (req.row > last_row) ? last_row : req.row;
    col_c = (req.col > last_col_eff) ? last_col_eff : req.col;
    if (!display_mode) begin
      // split single row: upper half of the line lives at 0x40
      addr = {col_c[3], 3'b000, col_c[2:0]};
    end else begin
      addr = 7'({2'b00, col_c}) + clc_pkg::row_offset(row_c);
    end
    res.pos.row = row_c;
    res.pos.col = col_c;
    res.instr   = clc_pkg::INSTR_SET_ADDR | {1'b0, addr};
  end

endmodule

[hdl/clc_checker.sv]
module clc_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       in_valid,
  input logic       in_ready,
  input logic       out_valid,
  input logic       out_ready,
  input logic [3:0] out_nibble,
  input logic       out_reg_select,
  input logic       out_long_wait,
  input logic       out_last
);

  // a command keeps the block busy for at least the next cycle
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("input accepted back to back");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_nibble) &&
      $stable(out_reg_select) && $stable(out_long_wait) && $stable(out_last))
    else $error("stalled output beat changed");

  // clear and home are instructions, never data
  a_long_wait_instr: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_long_wait |-> !out_reg_select)
    else $error("long wait on a data write");

  a_reset_quiet: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("output beat right after reset");

endmodule

bind char_lcd_cursor_controller_core clc_checker u_clc_checker (
  .clk            (clk),
  .rst_n          (rst_n),
  .in_valid       (in_bus.valid),
  .in_ready       (in_bus.ready),
  .out_valid      (out_bus.valid),
  .out_ready      (out_bus.ready),
  .out_nibble     (out_bus.nibble),
  .out_reg_select (out_bus.reg_select),
  .out_long_wait  (out_bus.long_wait),
  .out_last       (out_bus.last)
);

[test/tb_top.sv]
module tb_top;

  // quiet cycles allowed before the run is declared hung; the long
  // receiver hold-off below is the longest legal quiet stretch
  localparam int WATCHDOG_LIMIT = 3000;
  localparam int HOLD_OFF_CYCLES = 400;
  // cycles left after the last nibble so a write-free command can finish
  localparam int SETTLE_CYCLES = 30;
  // most nibble writes one command can cause
  localparam int MAX_WRITES = 42;

  typedef struct {
    logic [3:0] cmd;
    logic [7:0] char_code;
    logic [1:0] target_row;
    logic [4:0] target_col;
    logic       cursor_visible;
    logic       cursor_blink;
  } host_cmd_t;

  typedef struct {
    logic [3:0] nibble;
    logic       reg_select;
    logic       long_wait;
    logic       last;
  } lcd_write_t;

  logic clk = 1'b0;
  logic rst_n;

  clc_in_if  in_if ();
  clc_out_if out_if ();
  clc_cfg_if cfg_if ();

  char_lcd_cursor_controller_core uut (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_bus  (in_if),
    .out_bus (out_if),
    .cfg_bus (cfg_if)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // ---------------------------------------------------------------
  // terminal tracking: display settings, cursor and saved position
  // ---------------------------------------------------------------
  logic       cfg_multi_row = 1'b1;
  logic [1:0] cfg_last_row  = 2'd1;
  logic [4:0] cfg_last_col  = 5'd15;

  logic [4:0] cur_col   = '0;
  logic [1:0] cur_row   = '0;
  logic [4:0] saved_col = '0;
  logic [1:0] saved_row = '0;
  logic       clr_pend  = 1'b0;

  // ddram start address of each row in multi-row addressing
  int row_base [4] = '{'h00, 'h40, 'h14, 'h54};

  lcd_write_t cmd_writes[$];       // writes of the command being tracked
  lcd_write_t nibble_writes_q[$];  // writes still owed by the block
  host_cmd_t  host_cmds_q[$];      // commands waiting to be offered

  int cmds_queued  = 0;
  int cmds_taken   = 0;
  int beats_seen   = 0;
  int fail_cnt     = 0;
  int settings_run = 1;

  // last usable column, capped at the widest supported display
  function automatic logic [4:0] col_limit();
    return (cfg_last_col > clc_pkg::MAX_LAST_COL) ? clc_pkg::MAX_LAST_COL : cfg_last_col;
  endfunction

  function automatic void add_nibble(logic [3:0] n, logic rs, logic lw);
    lcd_write_t w;
    w.nibble     = n;
    w.reg_select = rs;
    w.long_wait  = lw;
    w.last       = 1'b0;
    // the write buffer of one command saturates
    if (cmd_writes.size() < MAX_WRITES)
      cmd_writes.push_back(w);
  endfunction

  // one byte goes out as two nibbles, high first
  function automatic void add_byte(logic [7:0] b, logic rs, logic lw);
    add_nibble(b[7:4], rs, lw);
    add_nibble(b[3:0], rs, lw);
  endfunction

  // set-address write: clamp, map to ddram address, drop pending clear
  function automatic void set_addr(int row, int col);
    int addr;
    if (row > cfg_last_row) row = cfg_last_row;
    if (col > col_limit()) col = col_limit();
    if (!cfg_multi_row)
      addr = (col % 8) + 'h40 * ((col / 8) % 2);
    else
      addr = col + row_base[row];
    add_byte(clc_pkg::INSTR_SET_ADDR | 8'(addr & 'h7F), 1'b0, 1'b0);
    cur_col  = 5'(col);
    cur_row  = 2'(row);
    clr_pend = 1'b0;
  endfunction

  function automatic void line_start();
    set_addr(cur_row, 0);
  endfunction

  // next row; wrapping past the bottom arms the deferred clear
  function automatic void line_down();
    int  r;
    logic wrapped;
    r = cur_row + 1;
    wrapped = 1'b0;
    if (r > cfg_last_row) begin
      r = 0;
      wrapped = 1'b1;
    end
    set_addr(r, cur_col);
    if (wrapped) clr_pend = 1'b1;
  endfunction

  function automatic void blank_screen();
    add_byte(clc_pkg::INSTR_CLEAR, 1'b0, 1'b1);
    cur_col  = '0;
    cur_row  = '0;
    clr_pend = 1'b0;
  endfunction

  function automatic void type_char(logic [7:0] c);
    int col;
    if (clr_pend) blank_screen();
    if (c == clc_pkg::CHAR_NEWLINE) begin
      line_start();
      line_down();
      return;
    end
    add_byte(c, 1'b1, 1'b0);
    col = cur_col + 1;
    cur_col = 5'(col);
    if (col > col_limit()) begin
      line_start();
      line_down();
    end
    // split addressing jumps from the left to the right half at column 8
    if (!cfg_multi_row && cur_col == clc_pkg::SPLIT_COL) set_addr(0, cur_col);
  endfunction

  // track one accepted command and append the writes it owes
  function automatic void terminal_apply(host_cmd_t hc);
    int       stop_col;
    logic     keep;
    cmd_writes.delete();
    case (hc.cmd)
      clc_pkg::CMD_PUTC:   type_char(hc.char_code);
      clc_pkg::CMD_MOVE:   set_addr(hc.target_row, hc.target_col);
      clc_pkg::CMD_LEFT: begin
        if (cur_col > 0) cur_col = cur_col - 1'b1;
        set_addr(cur_row, cur_col);
      end
      clc_pkg::CMD_RIGHT: begin
        if (cur_col < col_limit()) begin
          cur_col = cur_col + 1'b1;
          set_addr(cur_row, cur_col);
        end else begin
          // wrap to next line; the repeated address keeps the armed clear
          line_start();
          line_down();
          keep = clr_pend;
          set_addr(cur_row, cur_col);
          clr_pend = keep;
        end
      end
      clc_pkg::CMD_UP: begin
        if (cur_row > 0) cur_row = cur_row - 1'b1;
        set_addr(cur_row, cur_col);
      end
      clc_pkg::CMD_DOWN:   line_down();
      clc_pkg::CMD_RETURN: line_start();
      clc_pkg::CMD_CLEAR:  blank_screen();
      clc_pkg::CMD_HOME: begin
        add_byte(clc_pkg::INSTR_HOME, 1'b0, 1'b1);
        cur_col = '0;
        cur_row = '0;
      end
      clc_pkg::CMD_CURSOR:
        add_byte(clc_pkg::INSTR_DISP_ON | {6'b0, hc.cursor_visible, hc.cursor_blink},
                 1'b0, 1'b0);
      clc_pkg::CMD_SAVE: begin
        saved_col = cur_col;
        saved_row = cur_row;
      end
      clc_pkg::CMD_RECALL: set_addr(saved_row, saved_col);
      clc_pkg::CMD_ERASE: begin
        // spaces up to one column short of the end, count fixed at start
        stop_col = col_limit();
        for (int i = cur_col; i < stop_col; i++) type_char(clc_pkg::CHAR_SPACE);
      end
      default: ;
    endcase
    if (cmd_writes.size() > 0) cmd_writes[cmd_writes.size() - 1].last = 1'b1;
    foreach (cmd_writes[i]) nibble_writes_q.push_back(cmd_writes[i]);
  endfunction

  // ---------------------------------------------------------------
  // host side: offers queued commands, with random gaps between them
  // ---------------------------------------------------------------
  logic      calm      = 1'b0;  // no idling on either side
  logic      cmd_up    = 1'b0;  // a command beat is on the bus
  logic      cmd_taken = 1'b0;  // set by the monitor on a command handshake
  int        host_gap  = 0;
  int        host_quiet = 0;
  host_cmd_t host_next;

  always @(negedge clk) begin
    if (!rst_n) begin
      in_if.valid <= 1'b0;
    end else begin
      if (cmd_taken) begin
        cmd_taken = 1'b0;
        cmd_up    = 1'b0;
      end
      if (!cmd_up) begin
        if (host_gap > 0) begin
          host_gap--;
        end else if (host_cmds_q.size() > 0) begin
          if (!calm && host_quiet == 0 && $urandom_range(0, 3) == 0) begin
            // gap burst, then a stretch of back-to-back commands
            host_gap   = $urandom_range(1, 14) - 1;
            host_quiet = $urandom_range(0, 30);
          end else begin
            host_next = host_cmds_q.pop_front();
            in_if.cmd            <= host_next.cmd;
            in_if.char_code      <= host_next.char_code;
            in_if.target_row     <= host_next.target_row;
            in_if.target_col     <= host_next.target_col;
            in_if.cursor_visible <= host_next.cursor_visible;
            in_if.cursor_blink   <= host_next.cursor_blink;
            cmd_up = 1'b1;
            if (host_quiet > 0) host_quiet--;
          end
        end
      end
      in_if.valid <= cmd_up;
    end
  end

  // ---------------------------------------------------------------
  // display side: ready with random stall bursts and one long hold-off
  // ---------------------------------------------------------------
  logic hold_req  = 1'b0;
  int   hold_left = 0;
  int   disp_gap  = 0;
  int   disp_quiet = 0;

  always @(negedge clk) begin
    if (!rst_n) begin
      out_if.ready <= 1'b0;
    end else begin
      if (hold_req) begin
        hold_req  = 1'b0;
        hold_left = HOLD_OFF_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_if.ready <= 1'b0;
      end else if (disp_gap > 0) begin
        disp_gap--;
        out_if.ready <= 1'b0;
      end else if (!calm && disp_quiet == 0 && $urandom_range(0, 3) == 0) begin
        disp_gap   = $urandom_range(1, 14) - 1;
        disp_quiet = $urandom_range(0, 40);
        out_if.ready <= 1'b0;
      end else begin
        if (disp_quiet > 0) disp_quiet--;
        out_if.ready <= 1'b1;
      end
    end
  end

  // ---------------------------------------------------------------
  // monitor: track accepted commands, check every nibble beat
  // ---------------------------------------------------------------
  task automatic check_field(string name, logic [3:0] want, logic [3:0] got);
    if (got !== want) begin
      $error("%s: expected %0h, got %0h", name, want, got);
      fail_cnt++;
    end
  endtask

  lcd_write_t want_w;

  always @(posedge clk) begin
    if (rst_n && in_if.valid && in_if.ready) begin
      host_next.cmd            = in_if.cmd;
      host_next.char_code      = in_if.char_code;
      host_next.target_row     = in_if.target_row;
      host_next.target_col     = in_if.target_col;
      host_next.cursor_visible = in_if.cursor_visible;
      host_next.cursor_blink   = in_if.cursor_blink;
      terminal_apply(host_next);
      cmd_taken = 1'b1;
      cmds_taken++;
    end
    if (rst_n && out_if.valid && out_if.ready) begin
      beats_seen++;
      if (nibble_writes_q.size() == 0) begin
        $error("nibble beat %0h with no write outstanding", out_if.nibble);
        fail_cnt++;
      end else begin
        want_w = nibble_writes_q.pop_front();
        check_field("nibble", want_w.nibble, out_if.nibble);
        check_field("reg_select", {3'b0, want_w.reg_select}, {3'b0, out_if.reg_select});
        check_field("long_wait", {3'b0, want_w.long_wait}, {3'b0, out_if.long_wait});
        check_field("last", {3'b0, want_w.last}, {3'b0, out_if.last});
      end
    end
  end

  // hang detection: no beat of any kind for too long
  int quiet_cycles = 0;

  always @(posedge clk) begin
    if (!rst_n || (in_if.valid && in_if.ready) || (out_if.valid && out_if.ready) ||
        (cfg_if.valid && cfg_if.ready)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("[char_lcd_cursor_controller_core] ERROR");
        $finish;
      end
    end
  end

  // ---------------------------------------------------------------
  // stimulus helpers
  // ---------------------------------------------------------------
  task automatic queue_cmd(logic [3:0] c, logic [7:0] ch, logic [1:0] r, logic [4:0] col,
                           logic vis, logic blink);
    host_cmd_t hc;
    hc.cmd            = c;
    hc.char_code      = ch;
    hc.target_row     = r;
    hc.target_col     = col;
    hc.cursor_visible = vis;
    hc.cursor_blink   = blink;
    host_cmds_q.push_back(hc);
    cmds_queued++;
  endtask

  // characters four times in ten, the rest spread over every other code incl. unused ones
  task automatic queue_random(int n);
    logic [3:0] c;
    logic [7:0] ch;
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(0, 9) < 4) c = clc_pkg::CMD_PUTC;
      else c = 4'($urandom_range(1, 15));
      if ($urandom_range(0, 7) == 0) ch = clc_pkg::CHAR_NEWLINE;
      else ch = 8'($urandom);
      queue_cmd(c, ch, 2'($urandom), 5'($urandom), 1'($urandom), 1'($urandom));
    end
  endtask

  // block idle: every command taken, every write seen, then a margin
  task automatic settle();
    while (cmds_taken != cmds_queued || nibble_writes_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(logic [1:0] idx, logic [4:0] val);
    @(negedge clk);
    cfg_if.valid <= 1'b1;
    cfg_if.idx   <= idx;
    cfg_if.data  <= val;
    do @(posedge clk); while (!cfg_if.ready);
    case (idx)
      clc_pkg::CFG_DISPLAY_MODE: cfg_multi_row = val[0];
      clc_pkg::CFG_LAST_ROW:     cfg_last_row  = val[1:0];
      clc_pkg::CFG_LAST_COL:     cfg_last_col  = val;
      default: ;
    endcase
    @(negedge clk);
    cfg_if.valid <= 1'b0;
  endtask

  task automatic set_display(logic multi, logic [1:0] rows, logic [4:0] cols);
    write_reg(clc_pkg::CFG_DISPLAY_MODE, {4'b0, multi});
    write_reg(clc_pkg::CFG_LAST_ROW, {3'b0, rows});
    write_reg(clc_pkg::CFG_LAST_COL, cols);
    settings_run++;
  endtask

  // ---------------------------------------------------------------
  // test sequence
  // ---------------------------------------------------------------
  initial begin
    rst_n = 1'b0;
    in_if.valid          = 1'b0;
    in_if.cmd            = clc_pkg::CMD_PUTC;
    in_if.char_code      = '0;
    in_if.target_row     = '0;
    in_if.target_col     = '0;
    in_if.cursor_visible = 1'b0;
    in_if.cursor_blink   = 1'b0;
    out_if.ready         = 1'b0;
    cfg_if.valid         = 1'b0;
    cfg_if.idx           = clc_pkg::CFG_DISPLAY_MODE;
    cfg_if.data          = '0;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // directed, reset settings: two rows of sixteen, row offsets
    queue_cmd(clc_pkg::CMD_CURSOR, 8'h00, 2'd0, 5'd0, 1'b1, 1'b1);
    queue_cmd(clc_pkg::CMD_CURSOR, 8'h00, 2'd0, 5'd0, 1'b0, 1'b1);
    queue_cmd(clc_pkg::CMD_PUTC,   8'h00, 2'd0, 5'd0, 1'b0, 1'b0);
    queue_cmd(clc_pkg::CMD_PUTC,   8'hFF, 2'd3, 5'd31, 1'b1, 1'b0);
    queue_cmd(clc_pkg::CMD_LEFT,   8'h00, 2'd0, 5'd0, 1'b0, 1'b0);
    // target beyond the screen is clamped to the bottom-right corner
    queue_cmd(clc_pkg::CMD_MOVE,   8'h00, 2'd3, 5'd31, 1'b0, 1'b0);
    // char in the last column of the last row: wrap arms the clear
    queue_cmd(clc_pkg::CMD_PUTC,   8'h41, 2'd0, 5'd0, 1'b0, 1'b0);
    queue_cmd(clc_pkg::CMD_PUTC,   8'h42, 2'd0, 5'd0, 1'b0, 1'b0);
    queue_cmd(clc_pkg::CMD_MOVE,   8'h00, 2'd0, 5'd0, 1'b0, 1'b0);
    queue_cmd(clc_pkg::CMD_LEFT,   8'h00, 2'd0, 5'd0, 1'b0, 1'b0);
    queue_cmd(clc_pkg::CMD_UP,     8'h00, 2'd0, 5'd0, 1'b0, 1'b0);
    // right at the end of the bottom row keeps the clear armed
    queue_cmd(clc_pkg::CMD_MOVE,   8'h00, 2'd1, 5'd15, 1'b0, 1'b0);
    queue_cmd(clc_pkg::CMD_RIGHT,  8'h00, 2'd0, 5'd0, 1'b0, 1'b0);
    queue_cmd(clc_pkg::CMD_PUTC,   8'h7E, 2'd0, 5'd0, 1'b0, 1'b0);
    queue_cmd(clc_pkg::CMD_DOWN,   8'h00, 2'd0, 5'd0, 1'b0, 1'b0);
    // down wraps, home leaves the clear armed for the next char
    queue_cmd(clc_pkg::CMD_DOWN,   8'h00, 2'd0, 5'd0, 1'b0, 1'b0);
    queue_cmd(clc_pkg::CMD_HOME,   8'h00, 2'd0, 5'd0, 1'b0, 1'b0);
    queue_cmd(clc_pkg::CMD_PUTC,   clc_pkg::CHAR_NEWLINE, 2'd0, 5'd0, 1'b0, 1'b0);
    queue_cmd(clc_pkg::CMD_UP,     8'h00, 2'd0, 5'd0, 1'b0, 1'b0);
    queue_cmd(clc_pkg::CMD_MOVE,   8'h00, 2'd1, 5'd5, 1'b0, 1'b0);
    queue_cmd(clc_pkg::CMD_SAVE,   8'h00, 2'd0, 5'd0, 1'b0, 1'b0);
    queue_cmd(clc_pkg::CMD_RETURN, 8'h00, 2'd0, 5'd0, 1'b0, 1'b0);
    queue_cmd(clc_pkg::CMD_RECALL, 8'h00, 2'd0, 5'd0, 1'b0, 1'b0);
    queue_cmd(clc_pkg::CMD_ERASE,  8'h00, 2'd0, 5'd0, 1'b0, 1'b0);
    // erase at the last column writes nothing
    queue_cmd(clc_pkg::CMD_ERASE,  8'h00, 2'd0, 5'd0, 1'b0, 1'b0);
    queue_cmd(clc_pkg::CMD_CLEAR,  8'h00, 2'd0, 5'd0, 1'b0, 1'b0);
    queue_cmd(4'd13,               8'h00, 2'd0, 5'd0, 1'b0, 1'b0);
    queue_cmd(4'd15,               8'hFF, 2'd3, 5'd31, 1'b1, 1'b1);
    queue_random(20);
    settle();

    // split 8+8 single row: char landing on column 8 re-addresses
    set_display(1'b0, 2'd0, 5'd15);
    queue_cmd(clc_pkg::CMD_MOVE,   8'h00, 2'd0, 5'd7, 1'b0, 1'b0);
    queue_cmd(clc_pkg::CMD_PUTC,   8'h38, 2'd0, 5'd0, 1'b0, 1'b0);
    queue_cmd(clc_pkg::CMD_RETURN, 8'h00, 2'd0, 5'd0, 1'b0, 1'b0);
    queue_cmd(clc_pkg::CMD_ERASE,  8'h00, 2'd0, 5'd0, 1'b0, 1'b0);
    queue_random(40);
    settle();

    // widest screen; display side holds off long so input backs up
    set_display(1'b1, 2'd3, 5'd19);
    queue_random(40);
    hold_req = 1'b1;
    settle();

    // single cell
    set_display(1'b1, 2'd0, 5'd0);
    queue_random(20);
    settle();

    // last column above the supported width acts as the widest
    set_display(1'b0, 2'd1, 5'd31);
    queue_random(40);
    settle();

    // closing stretch at full rate on both sides
    set_display(1'b1, 2'd2, 5'd7);
    calm = 1'b1;
    queue_random(40);
    settle();

    $display("%0d commands under %0d display settings, %0d nibble writes checked",
             cmds_taken, settings_run, beats_seen);
    if (fail_cnt == 0 && nibble_writes_q.size() == 0)
      $display("[char_lcd_cursor_controller_core] OK");
    else
      $display("[char_lcd_cursor_controller_core] ERROR");
    $finish;
  end

endmodule
